/* src/vfct_pkg.sv */
package vfct_pkg;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 4;
   localparam int VAL_W    = 32;
   localparam int RAD_W    = 31;
   localparam int WIDE_W   = 68;
   localparam int CNT_W    = 7;
   localparam int NPLANES  = 6;

   // Request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_MV   = 3'd0,
      CMD_LOAD_PJ   = 3'd1,
      CMD_BUILD     = 3'd2,
      CMD_POINT     = 3'd3,
      CMD_SPHERE    = 3'd4,
      CMD_BOX_FULL  = 3'd5,
      CMD_BOX_ISECT = 3'd6
   } cmd_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       ld_mv;
      logic       ld_pj;
      logic       capture;
      logic       clip_issue;
      logic [5:0] clip_idx;
      logic       raw_en;
      logic       sq_issue;
      logic [1:0] k;
      logic [2:0] plane;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_done;
      logic       plane_wr;
      logic       test_issue;
      logic       rsp_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic len_zero;
   } dp_stat_type;

   // Clip column combined with the fourth column for each plane
   function automatic logic [1:0] plane_col(input logic [2:0] p);
      logic [1:0] c;
      case (p)
         3'd0, 3'd1: c = 2'd0;
         3'd2, 3'd3: c = 2'd1;
         default:    c = 2'd2;
      endcase
      return c;
   endfunction

   // Planes that subtract the other column
   function automatic logic plane_neg(input logic [2:0] p);
      return (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
   endfunction

   // Clamp a wide signed value to 32 bits
   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > WIDE_W'(64'sh7FFF_FFFF))
         r = 32'sh7FFF_FFFF;
      else if (v < -WIDE_W'(64'sh8000_0000))
         r = 32'sh8000_0000;
      else
         r = v[VAL_W-1:0];
      return r;
   endfunction

endpackage

/* src/vfct_ifs.sv */
interface vfct_req_if import vfct_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [IDX_W-1:0]          matrix_index;
   logic signed [VAL_W-1:0]   matrix_value;
   logic signed [VAL_W-1:0]   first_x;
   logic signed [VAL_W-1:0]   first_y;
   logic signed [VAL_W-1:0]   first_z;
   logic signed [VAL_W-1:0]   second_x;
   logic signed [VAL_W-1:0]   second_y;
   logic signed [VAL_W-1:0]   second_z;
   logic [RAD_W-1:0]          radius;

   modport source (output valid, command, matrix_index, matrix_value, first_x, first_y,
                   first_z, second_x, second_y, second_z, radius, input ready);
   modport sink (input valid, command, matrix_index, matrix_value, first_x, first_y,
                 first_z, second_x, second_y, second_z, radius, output ready);
endinterface

interface vfct_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

/* src/view_frustum_cull_tester.sv */
// A test works one plane per cycle through six 32x32 multipliers and eight
// corner adders, then drains the pipeline. A build is paced by the shared
// multiplier and the bit-serial square root and divider; the divide steps are
// skipped for a plane with a zero normal.
// One request is worked at a time. Synchronous active-high reset clears both
// matrices and the plane table to zero.
module view_frustum_cull_tester import vfct_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   vfct_req_if.sink  req_bus,
   vfct_rsp_if.source rsp_bus
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   vfct_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (cmd_type'(req_bus.command)),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   vfct_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_command (req_bus.command),
      .req_index   (req_bus.matrix_index),
      .req_value   (req_bus.matrix_value),
      .req_x1      (req_bus.first_x),
      .req_y1      (req_bus.first_y),
      .req_z1      (req_bus.first_z),
      .req_x2      (req_bus.second_x),
      .req_y2      (req_bus.second_y),
      .req_z2      (req_bus.second_z),
      .req_radius  (req_bus.radius),
      .rsp_inside  (rsp_bus.inside_res)
   );

endmodule

/* src/vfct_ctrl.sv */
module vfct_ctrl import vfct_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  cmd_type     req_cmd,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam int DIV_W = 32 + FRAC_BITS;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_CLIP  = 9'b000000010,
      ST_RAW   = 9'b000000100,
      ST_SQ    = 9'b000001000,
      ST_SQRT  = 9'b000010000,
      ST_DIV   = 9'b000100000,
      ST_WRITE = 9'b001000000,
      ST_TEST  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       k_ff, k_in;
   logic [2:0]       p_ff, p_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.k        = k_ff;
      cmd.plane    = p_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            k_in      = '0;
            p_in      = '0;
            if (req_valid) begin
               case (req_cmd)
                  CMD_LOAD_MV: cmd.ld_mv = 1'b1;
                  CMD_LOAD_PJ: cmd.ld_pj = 1'b1;
                  CMD_BUILD:   state_in = ST_CLIP;
                  CMD_POINT, CMD_SPHERE, CMD_BOX_FULL, CMD_BOX_ISECT: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_TEST;
                  end
                  default: ;
               endcase
            end
         end
         // 64 products, then the accumulator drains before ST_RAW
         ST_CLIP: begin
            cmd.clip_idx = cnt_ff[5:0];
            if (cnt_ff[6]) begin
               cnt_in   = '0;
               state_in = ST_RAW;
            end else begin
               cmd.clip_issue = 1'b1;
               cnt_in         = cnt_ff + 1'b1;
            end
         end
         ST_RAW: begin
            cmd.raw_en = 1'b1;
            if (k_ff == 2'd3) begin
               k_in     = '0;
               state_in = ST_SQ;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_SQ: begin
            cmd.k = cnt_ff[1:0];
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = ST_SQRT;
            end else begin
               cmd.sq_issue = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_init = (cnt_ff == '0);
            cmd.sqrt_step = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(32)) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if ((cnt_ff == '0 && stat.len_zero) || cnt_ff == CNT_W'(DIV_W + 1)) begin
               cmd.div_done = 1'b1;
               cnt_in       = '0;
               if (k_ff == 2'd3) begin
                  k_in     = '0;
                  state_in = ST_WRITE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               cmd.div_init = (cnt_ff == '0);
               cmd.div_step = (cnt_ff != '0);
               cnt_in       = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.plane_wr = 1'b1;
            if (p_ff == 3'(NPLANES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = ST_RAW;
            end
         end
         // six planes issued, then the pipeline drains
         ST_TEST: begin
            cmd.plane      = cnt_ff[2:0];
            cmd.test_issue = (cnt_ff < CNT_W'(NPLANES));
            if (cnt_ff == CNT_W'(NPLANES + 1)) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         p_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/vfct_dp.sv */
module vfct_dp import vfct_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [IDX_W-1:0]        req_index,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic signed [VAL_W-1:0] req_x1,
   input  logic signed [VAL_W-1:0] req_y1,
   input  logic signed [VAL_W-1:0] req_z1,
   input  logic signed [VAL_W-1:0] req_x2,
   input  logic signed [VAL_W-1:0] req_y2,
   input  logic signed [VAL_W-1:0] req_z2,
   input  logic [RAD_W-1:0]        req_radius,
   output logic                    rsp_inside
);

   localparam int DIV_W = 32 + FRAC_BITS;

   // Matrices and plane table
   logic signed [VAL_W-1:0] mv_ff [16];
   logic signed [VAL_W-1:0] pj_ff [16];
   logic signed [VAL_W-1:0] plane_ff [NPLANES][4];
   logic signed [VAL_W-1:0] clip_ff [4][4];

   // Build registers
   logic signed [63:0]      bprod_ff;
   logic                    clip_vld_ff, sq_vld_ff;
   logic [5:0]              clip_idx_ff;
   logic [1:0]              sq_k_ff;
   logic signed [65:0]      acc_ff;
   logic signed [VAL_W-1:0] v_ff [4];
   logic signed [VAL_W-1:0] coef_ff [4];
   logic [63:0]             n2_ff, sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [DIV_W-1:0]        dvd_ff;
   logic [31:0]             rem_ff;
   logic                    neg_ff;

   // Test registers
   logic signed [VAL_W-1:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff;
   logic [RAD_W-1:0]        rad_ff;
   cmd_type                 tcmd_ff;
   logic signed [63:0]      prod_ff [6];
   logic signed [VAL_W-1:0] d_ff;
   logic                    a_vld_ff, b_vld_ff;
   logic signed [WIDE_W-1:0] s_ff [8];
   logic                    pass_ff, rsp_ff;

   // Combinational
   logic signed [VAL_W-1:0]  bmul_a, bmul_b;
   logic signed [65:0]       acc_sum;
   logic signed [WIDE_W-1:0] clip_wide;
   logic signed [VAL_W-1:0]  raw_w, raw_o;
   logic signed [WIDE_W-1:0] raw_sum;
   logic [63:0]              sq_trial;
   logic [32:0]              div_trial;
   logic [32:0]              vmag;
   logic signed [WIDE_W-1:0] q_wide;
   logic signed [WIDE_W-1:0] s_next [8];
   logic [7:0]               pos;
   logic                     sph_ok, plane_ok;

   assign stat.len_zero = (sq_res_ff == '0);
   assign rsp_inside    = rsp_ff;

   // Shared build multiplier operands
   assign bmul_a = cmd.clip_issue ? mv_ff[{cmd.clip_idx[5:4], cmd.clip_idx[1:0]}] : v_ff[cmd.k];
   assign bmul_b = cmd.clip_issue ? pj_ff[{cmd.clip_idx[1:0], cmd.clip_idx[3:2]}] : v_ff[cmd.k];

   // Clip accumulation, floor shift and clamp
   assign acc_sum   = ((clip_idx_ff[1:0] == 2'd0) ? 66'sd0 : acc_ff)
                      + {{2{bprod_ff[63]}}, bprod_ff};
   assign clip_wide = WIDE_W'(acc_sum >>> FRAC_BITS);

   // Raw plane coefficient
   assign raw_w   = clip_ff[cmd.k][3];
   assign raw_o   = clip_ff[cmd.k][plane_col(cmd.plane)];
   assign raw_sum = plane_neg(cmd.plane) ? (WIDE_W'(raw_w) - WIDE_W'(raw_o))
                                         : (WIDE_W'(raw_w) + WIDE_W'(raw_o));

   // Square root and divide steps
   assign sq_trial  = sq_res_ff + sq_bit_ff;
   assign div_trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign vmag      = v_ff[cmd.k][VAL_W-1] ? (~{1'b1, v_ff[cmd.k]} + 33'd1)
                                           : {1'b0, v_ff[cmd.k]};
   assign q_wide    = WIDE_W'({1'b0, dvd_ff});

   // Corner distances
   always_comb begin
      for (int c = 0; c < 8; c++) begin
         s_next[c] = WIDE_W'(prod_ff[c % 2]) + WIDE_W'(prod_ff[2 + (c / 2) % 2])
                     + WIDE_W'(prod_ff[4 + c / 4]) + (WIDE_W'(d_ff) <<< FRAC_BITS);
         pos[c]    = (s_ff[c] > 0);
      end
   end

   // Radius is nonnegative; keep the sum signed
   assign sph_ok = (s_ff[0] + ($signed(WIDE_W'({1'b0, rad_ff})) <<< FRAC_BITS)) > 0;

   always_comb begin
      case (tcmd_ff)
         CMD_POINT:     plane_ok = pos[0];
         CMD_SPHERE:    plane_ok = sph_ok;
         CMD_BOX_FULL:  plane_ok = &pos;
         CMD_BOX_ISECT: plane_ok = |pos;
         default:       plane_ok = 1'b1;
      endcase
   end

   // State with defined reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mv_ff[i] <= '0;
            pj_ff[i] <= '0;
         end
         for (int p = 0; p < NPLANES; p++)
            for (int k = 0; k < 4; k++)
               plane_ff[p][k] <= '0;
         clip_vld_ff <= 1'b0;
         sq_vld_ff   <= 1'b0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         pass_ff     <= 1'b1;
         rsp_ff      <= 1'b0;
      end else begin
         if (cmd.ld_mv)
            mv_ff[req_index] <= req_value;
         if (cmd.ld_pj)
            pj_ff[req_index] <= req_value;
         if (cmd.plane_wr)
            for (int k = 0; k < 4; k++)
               plane_ff[cmd.plane][k] <= coef_ff[k];
         clip_vld_ff <= cmd.clip_issue;
         sq_vld_ff   <= cmd.sq_issue;
         a_vld_ff    <= cmd.test_issue;
         b_vld_ff    <= a_vld_ff;
         if (cmd.capture)
            pass_ff <= 1'b1;
         else if (b_vld_ff)
            pass_ff <= pass_ff & plane_ok;
         if (cmd.rsp_load)
            rsp_ff <= pass_ff;
      end
   end

   // Build datapath
   always_ff @(posedge clock) begin
      if (cmd.clip_issue || cmd.sq_issue)
         bprod_ff <= bmul_a * bmul_b;
      clip_idx_ff <= cmd.clip_idx;
      sq_k_ff     <= cmd.k;
      if (clip_vld_ff) begin
         acc_ff <= acc_sum;
         if (clip_idx_ff[1:0] == 2'd3)
            clip_ff[clip_idx_ff[5:4]][clip_idx_ff[3:2]] <= sat32(clip_wide);
      end
      if (cmd.raw_en)
         v_ff[cmd.k] <= sat32(raw_sum);
      if (sq_vld_ff)
         n2_ff <= ((sq_k_ff == 2'd0) ? 64'd0 : n2_ff) + 64'(bprod_ff);
      if (cmd.sqrt_init) begin
         sq_rem_ff <= n2_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (sq_rem_ff >= sq_trial) begin
            sq_rem_ff <= sq_rem_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.div_init) begin
         neg_ff <= v_ff[cmd.k][VAL_W-1];
         dvd_ff <= DIV_W'(vmag[31:0]) << FRAC_BITS;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (div_trial >= {1'b0, sq_res_ff[31:0]}) begin
            rem_ff <= 32'(div_trial - {1'b0, sq_res_ff[31:0]});
            dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= div_trial[31:0];
            dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
         end
      end
      if (cmd.div_done)
         coef_ff[cmd.k] <= stat.len_zero ? v_ff[cmd.k]
                                         : sat32(neg_ff ? -q_wide : q_wide);
   end

   // Test datapath: capture, six products per plane, corner sums
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x1_ff   <= req_x1;
         y1_ff   <= req_y1;
         z1_ff   <= req_z1;
         x2_ff   <= req_x2;
         y2_ff   <= req_y2;
         z2_ff   <= req_z2;
         rad_ff  <= req_radius;
         tcmd_ff <= cmd_type'(req_command);
      end
      if (cmd.test_issue) begin
         prod_ff[0] <= plane_ff[cmd.plane][0] * x1_ff;
         prod_ff[1] <= plane_ff[cmd.plane][0] * x2_ff;
         prod_ff[2] <= plane_ff[cmd.plane][1] * y1_ff;
         prod_ff[3] <= plane_ff[cmd.plane][1] * y2_ff;
         prod_ff[4] <= plane_ff[cmd.plane][2] * z1_ff;
         prod_ff[5] <= plane_ff[cmd.plane][2] * z2_ff;
         d_ff       <= plane_ff[cmd.plane][3];
      end
      if (a_vld_ff)
         for (int c = 0; c < 8; c++)
            s_ff[c] <= s_next[c];
   end

endmodule
